/* sv/usan_pkg.sv */
package usan_pkg;

	localparam int unsigned QueueDepth = 8;
	localparam int unsigned QueuePtrW = $clog2(QueueDepth);
	localparam int unsigned QueueCntW = $clog2(QueueDepth + 1);
	localparam int unsigned GroupMax = 4;

	localparam logic [7:0] AsciiMax = 8'h7F;
	localparam logic [7:0] ContMask = 8'hC0;
	localparam logic [7:0] ContCode = 8'h80;
	localparam logic [7:0] Lead2Mask = 8'hE0;
	localparam logic [7:0] Lead2Code = 8'hC0;
	localparam logic [7:0] Lead3Mask = 8'hF0;
	localparam logic [7:0] Lead3Code = 8'hE0;
	localparam logic [7:0] Lead4Mask = 8'hF8;
	localparam logic [7:0] Lead4Code = 8'hF0;

	typedef struct packed {
		logic [2:0]      count;
		logic [3:0][7:0] bytes;
	} grp_t;

endpackage

/* sv/usan_core.sv */
module usan_core import usan_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       data_valid,
	output logic       data_ready,
	input  logic [7:0] data_byte,
	input  logic       end_of_message,
	input  logic       room,
	output grp_t       grp
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eom_s1;
	logic       fire;

	logic [7:0] held_q [3];
	logic [2:0] exp_q;
	logic [1:0] cnt_q;

	logic       pending;
	logic       is_cont;
	logic       complete;
	logic [2:0] lead_len;

	logic [2:0] exp_d;
	logic [1:0] cnt_d;
	logic       store_cont;
	logic       store_lead;

	assign fire = valid_s1 && room;
	assign data_ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (data_ready) begin
			valid_s1 <= data_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (data_ready && data_valid) begin
			byte_s1 <= data_byte;
			eom_s1 <= end_of_message;
		end
	end

	assign pending = exp_q != 3'd0;
	assign is_cont = (byte_s1 & ContMask) == ContCode;
	assign complete = ({1'b0, cnt_q} + 3'd1) >= exp_q;

	always_comb begin
		priority if ((byte_s1 & Lead2Mask) == Lead2Code) begin
			lead_len = 3'd2;
		end else if ((byte_s1 & Lead3Mask) == Lead3Code) begin
			lead_len = 3'd3;
		end else if ((byte_s1 & Lead4Mask) == Lead4Code) begin
			lead_len = 3'd4;
		end else begin
			lead_len = 3'd0;
		end
	end

	always_comb begin
		grp.count = 3'd0;
		exp_d = exp_q;
		cnt_d = cnt_q;
		store_cont = 1'b0;
		store_lead = 1'b0;
		for (int k = 0; k < GroupMax; k++) begin
			if (k < 3 && k < int'(cnt_q)) begin
				grp.bytes[k] = held_q[k];
			end else begin
				grp.bytes[k] = byte_s1;
			end
		end
		if (pending && is_cont) begin
			if (complete) begin
				grp.count = {1'b0, cnt_q} + 3'd1;
				exp_d = 3'd0;
				cnt_d = 2'd0;
			end else begin
				store_cont = 1'b1;
				cnt_d = cnt_q + 2'd1;
				if (eom_s1) begin
					exp_d = 3'd0;
					cnt_d = 2'd0;
				end
			end
		end else begin
			exp_d = 3'd0;
			cnt_d = 2'd0;
			if (byte_s1 <= AsciiMax) begin
				grp.count = 3'd1;
				grp.bytes[0] = byte_s1;
			end else if (lead_len != 3'd0 && !eom_s1) begin
				store_lead = 1'b1;
				exp_d = lead_len;
				cnt_d = 2'd1;
			end
		end
		if (!fire) begin
			grp.count = 3'd0;
			exp_d = exp_q;
			cnt_d = cnt_q;
			store_cont = 1'b0;
			store_lead = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q <= 3'd0;
			cnt_q <= 2'd0;
		end else begin
			exp_q <= exp_d;
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (store_lead) begin
			held_q[0] <= byte_s1;
		end else if (store_cont) begin
			held_q[cnt_q] <= byte_s1;
		end
	end

endmodule

/* sv/usan_outq.sv */
module usan_outq import usan_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  grp_t                 grp,
	output logic                 room,
	output logic [QueueCntW-1:0] level,
	output logic                 result_valid,
	input  logic                 result_ready,
	output logic [7:0]           out_byte,
	output logic                 run_last
);

	logic [7:0]           byte_q [QueueDepth];
	logic                 last_q [QueueDepth];
	logic [QueuePtrW-1:0] wr_q;
	logic [QueuePtrW-1:0] rd_q;
	logic [QueueCntW-1:0] cnt_q;
	logic                 pop;

	assign pop = result_valid && result_ready;
	assign result_valid = cnt_q != '0;
	assign room = cnt_q <= QueueCntW'(QueueDepth - GroupMax);
	assign level = cnt_q;
	assign out_byte = byte_q[rd_q];
	assign run_last = last_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_q <= wr_q + QueuePtrW'(grp.count);
			rd_q <= rd_q + QueuePtrW'(pop);
			cnt_q <= cnt_q + QueueCntW'(grp.count) - QueueCntW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < GroupMax; k++) begin
			if (k < int'(grp.count)) begin
				byte_q[wr_q + QueuePtrW'(k)] <= grp.bytes[k];
				last_q[wr_q + QueuePtrW'(k)] <= (k == int'(grp.count) - 1);
			end
		end
	end

endmodule

/* sv/utf8_stream_sanitizer.sv */
// Passes structurally well-formed UTF-8 and drops everything else.
// The input channel (data_valid, data_ready) carries one text byte per beat
// together with end_of_message on the last byte of a message. The output
// channel (result_valid, result_ready) carries one sanitized byte per beat;
// run_last is set on the final output beat caused by one input beat.
// An ASCII byte comes out alone. A complete multibyte sequence comes out as
// a burst of two to four beats when its last continuation byte arrives.
// Input bytes are taken one per cycle while the queue has room. Each byte
// is held in an input register, then its output beats are written into an
// eight-entry output queue, from which they are offered in order.
// The output side drains one beat per cycle while result_ready is high;
// input waits only while the queue lacks room for a full four-beat burst.
// Reset clears the queue and any pending sequence. While the receiver
// stalls, the queue fills and then the input stops; no beat is lost.
module utf8_stream_sanitizer import usan_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       data_valid,
	output logic       data_ready,
	input  logic [7:0] data_byte,
	input  logic       end_of_message,
	output logic       result_valid,
	input  logic       result_ready,
	output logic [7:0] out_byte,
	output logic       run_last
);

	grp_t                 grp;
	logic                 room;
	logic [QueueCntW-1:0] level;

	usan_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.data_valid     (data_valid),
		.data_ready     (data_ready),
		.data_byte      (data_byte),
		.end_of_message (end_of_message),
		.room           (room),
		.grp            (grp)
	);

	usan_outq u_outq (
		.clk          (clk),
		.arst_n       (arst_n),
		.grp          (grp),
		.room         (room),
		.level        (level),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.out_byte     (out_byte),
		.run_last     (run_last)
	);

	a_group_size: assert property (@(posedge clk) disable iff (!arst_n)
		grp.count <= 3'(GroupMax))
		else $error("output group larger than four beats");

	a_write_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		grp.count != 3'd0 |-> level <= QueueCntW'(QueueDepth - GroupMax))
		else $error("group written without queue room");

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level <= QueueCntW'(QueueDepth))
		else $error("output queue overflow");

	a_write_shows: assert property (@(posedge clk) disable iff (!arst_n)
		grp.count != 3'd0 |=> result_valid)
		else $error("written group not offered");

endmodule
